// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker of the queue, supq_checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond at one edge implies prop at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/core/supq_pkg.sv =====
// Types and constants of the sorted unique priority queue.
// Used by the top level, the entry memory and the checker.
package supq_pkg;

   localparam int CMD_W = 2;
   localparam int KEY_W = 31;
   localparam int PAY_W = 32;
   localparam int ST_W  = 2;
   localparam int CNT_W = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
   localparam logic [ST_W-1:0] ST_MISS = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [KEY_W-1:0] out_key;
      logic [PAY_W-1:0] out_payload;
      logic             is_empty;
      logic [CNT_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_UP_RD,
      S_UP_WR,
      S_PLACE,
      S_POP_RD,
      S_POP_CAP,
      S_DN_RD,
      S_DN_WR,
      S_RESPOND
   } state_type;

endpackage

// ===== rtl/core/sorted_unique_priority_queue.sv =====
// Sorted unique priority queue: keys kept in ascending order in one memory, walked by a
// sequencer around one less-than and one equality key comparator. Depends on supq_pkg and supq_ram.
// A command is taken when start is high and busy is low; busy stays high until its one
// result has been shown on rsp_data with rsp_valid high for a single cycle, which the
// receiver must take then. The memory has one read and one write port, so each entry
// scanned or moved takes a read state and then a compare or write state. Search stops
// at the first key not below the requested one; insert then moves the larger entries
// up; extract returns slot zero and moves every remaining entry down. count reports
// the low 7 bits.
module sorted_unique_priority_queue import supq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C  = CW'(1);
   localparam logic [CW-1:0] ZERO_C = CW'(0);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [ST_W-1:0]  status_ff, status_in;
   logic [KEY_W-1:0] okey_ff, okey_in;
   logic [PAY_W-1:0] opay_ff, opay_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;
   logic [AW-1:0]    rd_addr;
   entry_type        rd_data;

   logic             key_lt;
   logic             key_eq;
   logic             at_end;
   logic             full;
   logic             scan_done;
   logic             scan_hit;
   logic             ins_go;

   supq_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign key_lt    = rd_data.key < req_ff.key;
   assign key_eq    = rd_data.key == req_ff.key;
   assign at_end    = idx_ff == count_ff;
   assign full      = count_ff == CAP_C;
   assign scan_done = ((state_ff == S_SCAN_RD) && at_end)
                   || ((state_ff == S_SCAN_CMP) && !key_lt);
   assign scan_hit  = (state_ff == S_SCAN_CMP) && key_eq;
   assign ins_go    = (req_ff.cmd == CMD_INSERT) && !scan_hit && !full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.cmd)
                  CMD_INSERT, CMD_SEARCH: state_in = S_SCAN_RD;
                  CMD_EXTRACT: state_in = (count_ff == ZERO_C) ? S_RESPOND : S_POP_RD;
                  default: state_in = S_RESPOND;
               endcase
            end
         end
         S_SCAN_RD: begin
            if (scan_done) begin
               state_in = ins_go ? S_PLACE : S_RESPOND;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (key_lt) begin
               state_in = S_SCAN_RD;
            end else begin
               state_in = ins_go ? S_UP_RD : S_RESPOND;
            end
         end
         S_UP_RD:   state_in = S_UP_WR;
         S_UP_WR:   state_in = (idx_ff == pos_ff) ? S_PLACE : S_UP_RD;
         S_PLACE:   state_in = S_RESPOND;
         S_POP_RD:  state_in = S_POP_CAP;
         S_POP_CAP: state_in = S_DN_RD;
         S_DN_RD:   state_in = at_end ? S_RESPOND : S_DN_WR;
         S_DN_WR:   state_in = S_DN_RD;
         S_RESPOND: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      status_in = status_ff;
      okey_in   = okey_ff;
      opay_in   = opay_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_data;
               idx_in    = ZERO_C;
               status_in = ST_MISS;
               okey_in   = '0;
               opay_in   = '0;
            end
         end
         S_SCAN_CMP: begin
            if (key_lt) begin
               idx_in = idx_ff + ONE_C;
            end
         end
         S_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff + ONE_C);
            if (idx_ff != pos_ff) begin
               idx_in = idx_ff - ONE_C;
            end
         end
         S_PLACE: begin
            wr_en           = 1'b1;
            wr_addr         = pos_ff[AW-1:0];
            wr_data.key     = req_ff.key;
            wr_data.payload = req_ff.payload;
            count_in        = count_ff + ONE_C;
         end
         S_POP_RD: begin
            rd_addr = '0;
         end
         S_POP_CAP: begin
            okey_in   = rd_data.key;
            opay_in   = rd_data.payload;
            status_in = ST_OK;
            idx_in    = ONE_C;
         end
         S_DN_RD: begin
            if (at_end) begin
               count_in = count_ff - ONE_C;
            end
         end
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff - ONE_C);
            idx_in  = idx_ff + ONE_C;
         end
         default: begin
         end
      endcase
      if (scan_done) begin
         pos_in = idx_ff;
         idx_in = count_ff - ONE_C;
         if (req_ff.cmd == CMD_SEARCH) begin
            status_in = scan_hit ? ST_OK : ST_MISS;
         end else if (scan_hit) begin
            status_in = ST_DUP;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= ZERO_C;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      okey_ff   <= okey_in;
      opay_ff   <= opay_in;
   end

   assign busy                 = state_ff != S_IDLE;
   assign rsp_valid            = state_ff == S_RESPOND;
   assign rsp_data.status      = status_ff;
   assign rsp_data.out_key     = okey_ff;
   assign rsp_data.out_payload = opay_ff;
   assign rsp_data.is_empty    = count_ff == ZERO_C;
   assign rsp_data.count       = CNT_W'(count_ff);

endmodule

// ===== rtl/core/supq_ram.sv =====
// Entry memory of the queue: one write port, one read port, registered read data.
// Depends on supq_pkg for the entry type.
module supq_ram import supq_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/supq_checker.sv =====
// Port-level checker of the sorted unique priority queue, bound to the top level.
// Depends on supq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module supq_checker import supq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic refused_clean;

   assign refused_clean = !rsp_valid || rsp_data.status == ST_OK
                       || (rsp_data.out_key == '0 && rsp_data.out_payload == '0);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after transfer")
   `ASSERT_ALWAYS(a_rsp_busy, clock, reset, !rsp_valid || busy, "result while idle")
   `ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "result longer than one cycle")
   `ASSERT_ALWAYS(a_fail_zero, clock, reset, refused_clean, "refused command returns data")

endmodule

bind sorted_unique_priority_queue supq_checker u_supq_checker (.*);
